// File: hw/rtl/odo_pkg.sv
// shared types, state codes and elaboration-time constants for the odometry unit
package odo_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
  localparam int CNT_W        = 6;
  localparam int REM_W        = 35;  // remainder width of the reduction by 2*pi in Q32

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  localparam logic [1:0] CFG_METERS_PER_TICK    = 2'd0;
  localparam logic [1:0] CFG_INVERSE_WHEELBASE  = 2'd1;
  localparam logic [1:0] CFG_REPORT_ZERO_DELTAS = 2'd2;

  localparam logic [31:0] MPT_RESET = 32'd560014;
  localparam logic [31:0] IWB_RESET = 32'd144671;

  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tbl_t;

  typedef struct packed {
    logic start;
    logic neg;
  } odo_mul_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_LD,
    ST_MUL_RD,
    ST_MUL_P,
    ST_MUL_H,
    ST_THETA,
    ST_REDUCE,
    ST_ROUND,
    ST_ZINIT,
    ST_FOLD,
    ST_CORDIC,
    ST_CS,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_DONE
  } odo_state_e;

  // long division, only used while building constants
  function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in Q62 by the alternating series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] q;
    t   = const_div(ONE_Q62, n);
    sum = '0;
    k   = '0;
    while (t != 64'd0) begin
      q = const_div(t, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - q;
      else sum = sum + q;
      t = const_div(t, n * n);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  // atan(2^-i) in Q62
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] q;
    t   = ONE_Q62 >> i;
    sum = '0;
    k   = '0;
    while (t != 64'd0) begin
      q = const_div(t, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - q;
      else sum = sum + q;
      t = (2 * i < 64) ? (t >> (2 * i)) : 64'd0;
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] calc_pi4();
    return (atan_recip(64'd5) << 2) - atan_recip(64'd239);
  endfunction

  function automatic atan_tbl_t calc_atan();
    atan_tbl_t tbl;
    tbl[0] = calc_pi4() >> 1;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      tbl[i] = atan_pow2(i) >> 1;
    end
    return tbl;
  endfunction

  // 1/K in Q61: square root of the product of 1/(1 + 4^-i)
  function automatic logic [63:0] calc_inv_gain();
    logic [63:0]  g;
    logic [63:0]  t;
    logic [63:0]  acc;
    logic         sub;
    logic [127:0] rad;
    logic [63:0]  r;
    logic [63:0]  c;
    g = ONE_Q62 >> 1;
    for (int i = 1; (i < CORDIC_STEPS) && (2 * i < 64); i++) begin
      t   = g >> (2 * i);
      acc = g;
      sub = 1'b1;
      while (t != 64'd0) begin
        acc = sub ? acc - t : acc + t;
        sub = !sub;
        t   = t >> (2 * i);
      end
      g = acc;
    end
    rad = {64'd0, g} << 62;
    r   = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= rad) r = c;
    end
    return r >> 1;
  endfunction

  localparam logic [63:0] PI4         = calc_pi4();
  localparam logic [63:0] PI_Q61      = PI4 << 1;
  localparam logic [63:0] HALF_PI_Q61 = PI4;
  localparam logic [63:0] TWO_PI_Q61  = PI4 << 2;
  localparam logic [63:0] TWO_PI_Q32  = PI4 >> 27;
  localparam logic [63:0] HALF_Q32    = TWO_PI_Q32 >> 1;
  localparam logic [63:0] INV_GAIN_Q61 = calc_inv_gain();
  localparam atan_tbl_t   ATAN_Q61    = calc_atan();

endpackage

// File: hw/rtl/odo_mul.sv
// shift-add multiplier, one multiplier bit per cycle, optional negate of the product
module odo_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  odo_pkg::odo_mul_req_t req_i,
  input  logic [63:0]          a_i,
  input  logic [63:0]          b_i,
  output logic [127:0]         prod_o,
  output logic                 done_o
);
  import odo_pkg::*;

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic        neg_q;
  logic        busy_q;
  logic        fin_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [64:0] sum;

  assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : 65'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (!fin_q) begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) fin_q <= 1'b1;
        end else begin
          busy_q <= 1'b0;
          fin_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      hi_q  <= '0;
      lo_q  <= '0;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      if (!fin_q) begin
        hi_q <= sum[64:1];
        lo_q <= {sum[0], lo_q[63:1]};
        b_q  <= {1'b0, b_q[63:1]};
      end else if (neg_q) begin
        {hi_q, lo_q} <= 128'd0 - {hi_q, lo_q};
      end
    end
  end

  assign prod_o = {hi_q, lo_q};
  assign done_o = done_q;

endmodule

// File: hw/rtl/odo_sqrt.sv
// integer square root of a 128-bit value, one root bit per cycle
module odo_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] rad_i,
  output logic [63:0]  root_o,
  output logic         done_o
);
  import odo_pkg::*;

  logic [127:0] rad_q;
  logic [65:0]  rem_q;
  logic [63:0]  root_q;
  logic         busy_q;
  logic         done_q;
  logic [5:0]   cnt_q;
  logic [67:0]  trial;
  logic [67:0]  t;
  logic         fits;

  assign t     = {rem_q, rad_q[127:126]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = (t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[125:0], 2'b00};
      if (fits) begin
        rem_q  <= 66'(t - trial);
        root_q <= {root_q[62:0], 1'b1};
      end else begin
        rem_q  <= t[65:0];
        root_q <= {root_q[62:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/differential_drive_odometry_unit.sv
// differential drive odometry: wheel sums, heading, midpoint position and range
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[63:0]: left_delta, right_delta
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[703:0]: ten 64-bit sums/steps, range
//  cfg       in   cfg_we_i (no ready)          cfg_idx_i selects, cfg_data_i[31:0]
//
// one item at a time; the time from one accepted item to the next is set by the eight
// serial multiplies through the shared shift-add multiplier, the bit-serial reduction by
// 2*pi and the bit-serial root
// s_axis_tready is high only in idle; an item with both deltas zero is dropped there
// unless zero reporting is on
// the result register holds the last item while the next one is being worked on;
// a finished item waits in the done state only if the previous result is not taken
// reset clears all accumulators and restores the register defaults
module differential_drive_odometry_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // left_delta, right_delta
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_tick_sum, right_tick_sum, left_distance, right_distance, center_step,
  // path_length, heading_step, heading, pos_x, pos_y, direct_distance, pad bit
  output logic [703:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  import odo_pkg::*;

  odo_state_e state_q, state_d;

  // configuration registers
  logic [31:0] mpt_q;
  logic [31:0] iwb_q;
  logic        rzd_q;

  // accumulators
  logic [63:0] lticks_q, rticks_q, ldist_q, rdist_q;
  logic [63:0] path_q, heading_q, xacc_q, yacc_q;

  // per-item working registers
  logic [31:0]       ld_q, rd_q;
  logic [63:0]       ldm_q;
  logic [63:0]       center_q;
  logic [63:0]       pmul_q;
  logic [63:0]       hstep_q;
  logic [63:0]       theta_q;
  logic [63:0]       dvd_q;
  logic [REM_W-1:0]  rem_q;
  logic [63:0]       qacc_q;
  logic [63:0]       z_q, x_q, y_q;
  logic              flip_q;
  logic [127:0]      sq_q;
  logic [62:0]       dist_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              go_q;

  // result register
  logic [703:0] out_q;
  logic         out_valid_q;

  // shared units
  odo_mul_req_t mul_req;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         mul_done;
  logic         sqrt_start;
  logic [63:0]  root;
  logic         sqrt_done;

  logic        in_acc;
  logic        in_zero;
  logic        load_out;
  logic        is_mul_st;
  logic [32:0] ld_mag, rd_mag, diff, diff_mag;
  logic [63:0] ld_ext, rd_ext;
  logic [63:0] center_mag, x_mag, xacc_mag, yacc_mag, y_mag;
  logic [63:0] rdm, center_new, theta_new;
  logic [63:0] dx, dy;
  logic [35:0] div_t;
  logic        div_bit;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign in_zero = (s_axis_tdata == 64'd0);

  assign ld_ext   = {{32{ld_q[31]}}, ld_q};
  assign rd_ext   = {{32{rd_q[31]}}, rd_q};
  assign ld_mag   = ld_q[31] ? 33'd0 - {ld_q[31], ld_q} : {1'b0, ld_q};
  assign rd_mag   = rd_q[31] ? 33'd0 - {rd_q[31], rd_q} : {1'b0, rd_q};
  assign diff     = {rd_q[31], rd_q} - {ld_q[31], ld_q};
  assign diff_mag = diff[32] ? 33'd0 - diff : diff;

  assign center_mag = center_q[63] ? 64'd0 - center_q : center_q;
  assign x_mag      = x_q[63] ? 64'd0 - x_q : x_q;
  assign y_mag      = y_q[63] ? 64'd0 - y_q : y_q;
  assign xacc_mag   = xacc_q[63] ? 64'd0 - xacc_q : xacc_q;
  assign yacc_mag   = yacc_q[63] ? 64'd0 - yacc_q : yacc_q;

  // right wheel step and center step (floor of the mean of both wheel steps)
  assign rdm        = prod[63:0];
  assign center_new = {ldm_q[63], ldm_q[63:1]} + {rdm[63], rdm[63:1]}
                    + {63'd0, ldm_q[0] & rdm[0]};
  // midpoint heading in Q32
  assign theta_new  = heading_q + {hstep_q[63], hstep_q[63:1]};

  // restoring division of |theta| by 2*pi, quotient bit by bit
  assign div_t   = {rem_q, dvd_q[63]};
  assign div_bit = (div_t >= TWO_PI_Q32[35:0]);

  assign dx = 64'($signed(y_q) >>> cnt_q);
  assign dy = 64'($signed(x_q) >>> cnt_q);

  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign is_mul_st = (state_q == ST_MUL_LD) || (state_q == ST_MUL_RD) ||
                     (state_q == ST_MUL_P)  || (state_q == ST_MUL_H)  ||
                     (state_q == ST_MUL_X)  || (state_q == ST_MUL_Y)  ||
                     (state_q == ST_SQ_X)   || (state_q == ST_SQ_Y);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && !(in_zero && !rzd_q)) state_d = ST_MUL_LD;
      ST_MUL_LD: if (mul_done) state_d = ST_MUL_RD;
      ST_MUL_RD: if (mul_done) state_d = ST_MUL_P;
      ST_MUL_P:  if (mul_done) state_d = ST_MUL_H;
      ST_MUL_H:  if (mul_done) state_d = ST_THETA;
      ST_THETA:  state_d = ST_REDUCE;
      ST_REDUCE: if (cnt_q == CNT_W'(63)) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_ZINIT;
      ST_ZINIT:  state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_CS;
      ST_CS:     state_d = ST_MUL_X;
      ST_MUL_X:  if (mul_done) state_d = ST_MUL_Y;
      ST_MUL_Y:  if (mul_done) state_d = ST_SQ_X;
      ST_SQ_X:   if (mul_done) state_d = ST_SQ_Y;
      ST_SQ_Y:   if (mul_done) state_d = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_d = ST_DONE;
      ST_DONE:   if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit operands and handshake outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mul_req.start = is_mul_st && !go_q;
    mul_req.neg   = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sqrt_start    = (state_q == ST_SQRT) && !go_q;
    case (state_q)
      ST_MUL_LD: begin
        mul_a       = {32'd0, mpt_q};
        mul_b       = {31'd0, ld_mag};
        mul_req.neg = ld_q[31];
      end
      ST_MUL_RD: begin
        mul_a       = {32'd0, mpt_q};
        mul_b       = {31'd0, rd_mag};
        mul_req.neg = rd_q[31];
      end
      ST_MUL_P: begin
        mul_a = {32'd0, mpt_q};
        mul_b = {32'd0, iwb_q};
      end
      ST_MUL_H: begin
        mul_a       = pmul_q;
        mul_b       = {31'd0, diff_mag};
        mul_req.neg = diff[32];
      end
      ST_MUL_X: begin
        mul_a       = center_mag;
        mul_b       = x_mag;
        mul_req.neg = center_q[63] ^ x_q[63];
      end
      ST_MUL_Y: begin
        mul_a       = center_mag;
        mul_b       = y_mag;
        mul_req.neg = center_q[63] ^ y_q[63];
      end
      ST_SQ_X: begin
        mul_a = xacc_mag;
        mul_b = xacc_mag;
      end
      ST_SQ_Y: begin
        mul_a = yacc_mag;
        mul_b = yacc_mag;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // control state, configuration and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mpt_q       <= MPT_RESET;
      iwb_q       <= IWB_RESET;
      rzd_q       <= 1'b0;
      lticks_q    <= '0;
      rticks_q    <= '0;
      ldist_q     <= '0;
      rdist_q     <= '0;
      path_q      <= '0;
      heading_q   <= '0;
      xacc_q      <= '0;
      yacc_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_METERS_PER_TICK:    mpt_q <= cfg_data_i;
          CFG_INVERSE_WHEELBASE:  iwb_q <= cfg_data_i;
          CFG_REPORT_ZERO_DELTAS: rzd_q <= cfg_data_i[0];
          default:                rzd_q <= rzd_q;
        endcase
      end

      // one launch per unit state
      if (mul_req.start || sqrt_start) go_q <= 1'b1;
      else if (mul_done || sqrt_done) go_q <= 1'b0;

      if (state_d != state_q) cnt_q <= '0;
      else if (state_q == ST_REDUCE || state_q == ST_CORDIC) cnt_q <= cnt_q + CNT_W'(1);

      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      if (mul_done) begin
        case (state_q)
          ST_MUL_LD: begin
            lticks_q <= lticks_q + ld_ext;
            ldist_q  <= ldist_q + prod[63:0];
          end
          ST_MUL_RD: begin
            rticks_q <= rticks_q + rd_ext;
            rdist_q  <= rdist_q + rdm;
            path_q   <= path_q + center_new;
          end
          ST_MUL_X: xacc_q <= xacc_q + prod[124:61];
          ST_MUL_Y: yacc_q <= yacc_q + prod[124:61];
          default:  xacc_q <= xacc_q;
        endcase
      end

      // heading moves after the midpoint angle is taken
      if (state_q == ST_THETA) heading_q <= heading_q + hstep_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ld_q <= s_axis_tdata[31:0];
      rd_q <= s_axis_tdata[63:32];
    end

    if (mul_done) begin
      case (state_q)
        ST_MUL_LD: ldm_q    <= prod[63:0];
        ST_MUL_RD: center_q <= center_new;
        ST_MUL_P:  pmul_q   <= prod[63:0];
        ST_MUL_H:  hstep_q  <= prod[79:16];
        ST_SQ_X:   sq_q     <= prod;
        ST_SQ_Y:   sq_q     <= sq_q + prod;
        default:   sq_q     <= sq_q;
      endcase
    end

    case (state_q)
      ST_THETA: begin
        theta_q <= theta_new;
        dvd_q   <= theta_new[63] ? 64'd0 - theta_new : theta_new;
        rem_q   <= '0;
        qacc_q  <= '0;
      end
      ST_REDUCE: begin
        dvd_q <= {dvd_q[62:0], 1'b0};
        if (div_bit) begin
          rem_q  <= REM_W'(div_t - TWO_PI_Q32[35:0]);
          qacc_q <= {qacc_q[62:0], 1'b0} + TWO_PI_Q61;
        end else begin
          rem_q  <= div_t[REM_W-1:0];
          qacc_q <= {qacc_q[62:0], 1'b0};
        end
      end
      // round the quotient to nearest
      ST_ROUND: if (rem_q > HALF_Q32[REM_W-1:0]) qacc_q <= qacc_q + TWO_PI_Q61;
      ST_ZINIT: begin
        z_q <= theta_q[63] ? {theta_q[34:0], 29'd0} + qacc_q
                           : {theta_q[34:0], 29'd0} - qacc_q;
      end
      // fold into the right half plane
      ST_FOLD: begin
        x_q <= INV_GAIN_Q61;
        y_q <= '0;
        if ($signed(z_q) > $signed(HALF_PI_Q61)) begin
          z_q    <= z_q - PI_Q61;
          flip_q <= 1'b1;
        end else if ($signed(z_q) < -$signed(HALF_PI_Q61)) begin
          z_q    <= z_q + PI_Q61;
          flip_q <= 1'b1;
        end else begin
          flip_q <= 1'b0;
        end
      end
      ST_CORDIC: begin
        if (!z_q[63]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - ATAN_Q61[cnt_q[CORDIC_IDX_W-1:0]];
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + ATAN_Q61[cnt_q[CORDIC_IDX_W-1:0]];
        end
      end
      ST_CS: begin
        if (flip_q) begin
          x_q <= 64'd0 - x_q;
          y_q <= 64'd0 - y_q;
        end
      end
      default: begin
        flip_q <= flip_q;
      end
    endcase

    // saturate the range at the largest 63-bit value
    if (sqrt_done) dist_q <= root[63] ? {63{1'b1}} : root[62:0];

    if (load_out) begin
      out_q <= {1'b0, dist_q, yacc_q, xacc_q, heading_q, hstep_q, path_q,
                center_q, rdist_q, ldist_q, rticks_q, lticks_q};
    end
  end

  odo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .done_o (mul_done)
  );

  odo_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sq_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_mul_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> is_mul_st)
    else $error("multiplier finished outside a multiply state");

  a_sqrt_done_in_sqrt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQRT))
    else $error("square root finished outside its state");

  a_zero_item_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_zero && !rzd_q) |=> (state_q == ST_IDLE))
    else $error("zero item started processing with zero reporting off");

  a_state_quiet_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> ($stable(heading_q) && $stable(xacc_q) && $stable(path_q)))
    else $error("accumulator changed while idle");

  a_result_held_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(out_q))
    else $error("result register overwritten before it was taken");
`endif

endmodule
